// ===== rtl/core/size_class_slab_allocator_defines.svh =====
// assertion macros shared by the slab allocator checker
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_DEFINES_SVH
// implication checked on every clock edge outside reset
`define SCSA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("slab allocator check failed");
// next-cycle implication
`define SCSA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("slab allocator check failed");
`endif

// ===== rtl/core/scsa_pkg.sv =====
// shared types and constants of the size-class slab allocator
package scsa_pkg;
    localparam int NUM_CLASSES         = 12;
    localparam int ARENA_GRANULES_LOG2 = 16;
    localparam int PAGE_BYTES          = 4096;
    localparam int CLS_W   = 4;
    localparam int GRAN_W  = ARENA_GRANULES_LOG2;
    localparam int LINK_W  = GRAN_W + 1;
    localparam int CNT_W   = GRAN_W + 1;
    localparam int LEFT_W  = 10;
    localparam int OFF_W   = 19;
    localparam int STAT_W  = 3;
    localparam int IN_W    = 1 + 32 + 1 + OFF_W + 1 + OFF_W;
    localparam int IN_BYTES_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W   = STAT_W + OFF_W + CLS_W + 1 + CNT_W;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [STAT_W-1:0] ST_ALLOC   = 3'd0;
    localparam logic [STAT_W-1:0] ST_LARGE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FAILED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FREED   = 3'd3;
    localparam logic [STAT_W-1:0] ST_IGNORED = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [31:0]       size_bytes;
        logic              object_present;
        logic [OFF_W-1:0]  object_offset;
        logic              page_valid;
        logic [OFF_W-1:0]  page_offset;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OFF_W-1:0]  granted_offset;
        logic [CLS_W-1:0]  size_class;
        logic              page_taken;
        logic [CNT_W-1:0]  class_in_use;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture request, start link read
        logic exec;    // apply update, build response
    } cmd_t;

    // smallest class that holds the size, NUM_CLASSES when none
    function automatic logic [CLS_W-1:0] pick_class(input logic [31:0] size);
        logic [CLS_W-1:0] c;
        c = CLS_W'(NUM_CLASSES);
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if ({32'd0, size} <= (64'd8 << i)) c = CLS_W'(i);
        end
        return c;
    endfunction
endpackage

// ===== rtl/core/scsa_ram.sv =====
// generic single-port ram with registered read
module scsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/core/scsa_ctrl.sv =====
// request sequencer of the slab allocator
module scsa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output scsa_pkg::cmd_t    cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign cmd.load = s_tready && s_tvalid;
    assign cmd.exec = (state_reg == S_EXEC);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_EXEC;
            S_EXEC: state_next = S_OUT;
            S_OUT:  if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end
endmodule

// ===== rtl/core/scsa_dp.sv =====
// class tables, link memory and result register of the slab allocator
module scsa_dp (
    input  logic           aclk,
    input  logic           aresetn,
    input  scsa_pkg::cmd_t cmd,
    input  scsa_pkg::req_t req,
    output scsa_pkg::rsp_t rsp
);
    localparam int NC = scsa_pkg::NUM_CLASSES;
    localparam int GW = scsa_pkg::GRAN_W;

    scsa_pkg::req_t req_reg;
    logic [scsa_pkg::CLS_W-1:0] cls_reg;
    logic [scsa_pkg::LINK_W-1:0] head_reg [NC];
    logic [GW-1:0] carve_reg [NC];
    logic [scsa_pkg::LEFT_W-1:0] left_reg [NC];
    logic [scsa_pkg::CNT_W-1:0] cnt_reg [NC];
    scsa_pkg::rsp_t rsp_reg, rsp_next;

    logic [scsa_pkg::CLS_W-1:0] cls_in;
    logic [scsa_pkg::CLS_W-1:0] ci;
    logic [GW-1:0] obj_gran, ram_addr;
    logic ram_we;
    logic [scsa_pkg::LINK_W-1:0] link_rd;

    // update of the class being served
    logic head_we, carve_we, left_we, cnt_we;
    logic [scsa_pkg::LINK_W-1:0] head_next;
    logic [GW-1:0] carve_next;
    logic [scsa_pkg::LEFT_W-1:0] left_next;
    logic [scsa_pkg::CNT_W-1:0] cnt_next;
    logic ok;
    logic [GW-1:0] grant;

    assign cls_in   = scsa_pkg::pick_class(req.size_bytes);
    assign obj_gran = GW'(req_reg.object_offset[scsa_pkg::OFF_W-1:3]);
    assign ci       = (cls_reg < scsa_pkg::CLS_W'(NC)) ? cls_reg : '0;

    // load: read link at head of the class; exec on free: write link at object
    always_comb begin
        ram_we = 1'b0;
        ram_addr = (cls_in < scsa_pkg::CLS_W'(NC)) ?
                   head_reg[cls_in][GW-1:0] : '0;
        if (cmd.exec && req_reg.opcode == scsa_pkg::OP_FREE &&
            req_reg.object_present && cls_reg < scsa_pkg::CLS_W'(NC)) begin
            ram_we = 1'b1;
            ram_addr = obj_gran;
        end
    end

    scsa_ram #(.WIDTH(scsa_pkg::LINK_W), .DEPTH(1 << GW)) u_link (
        .aclk (aclk), .we (ram_we), .addr (ram_addr),
        .wdata (head_reg[ci]), .rdata (link_rd)
    );

    logic [GW-1:0] step, pg_gran;
    logic [scsa_pkg::LEFT_W:0] cap;
    assign step    = GW'(1) << ci;
    assign cap     = (scsa_pkg::LEFT_W+1)'(scsa_pkg::PAGE_BYTES / 8) >> ci;
    assign pg_gran = GW'({req_reg.page_offset[scsa_pkg::OFF_W-1:12], 9'd0});

    always_comb begin
        rsp_next = '0;
        rsp_next.status = scsa_pkg::ST_IGNORED;
        head_we = 1'b0;
        carve_we = 1'b0;
        left_we = 1'b0;
        cnt_we = 1'b0;
        head_next = head_reg[ci];
        carve_next = carve_reg[ci];
        left_next = left_reg[ci];
        cnt_next = cnt_reg[ci];
        ok = 1'b0;
        grant = '0;
        if (req_reg.opcode == scsa_pkg::OP_FREE) begin
            if (req_reg.object_present) begin
                if (cls_reg >= scsa_pkg::CLS_W'(NC)) begin
                    rsp_next.status = scsa_pkg::ST_LARGE;
                end else begin
                    head_we = 1'b1;
                    head_next = {1'b1, obj_gran};
                    cnt_we = 1'b1;
                    cnt_next = (cnt_reg[ci] != '0) ? cnt_reg[ci] - 1'b1 : '0;
                    rsp_next.status = scsa_pkg::ST_FREED;
                    rsp_next.size_class = ci;
                    rsp_next.class_in_use = cnt_next;
                end
            end
        end else if (req_reg.size_bytes != '0) begin
            if (cls_reg >= scsa_pkg::CLS_W'(NC)) begin
                rsp_next.status = scsa_pkg::ST_LARGE;
            end else begin
                ok = 1'b1;
                rsp_next.size_class = ci;
                if (head_reg[ci][GW]) begin
                    grant = head_reg[ci][GW-1:0];
                    head_we = 1'b1;
                    head_next = link_rd;
                end else if (left_reg[ci] != '0) begin
                    grant = carve_reg[ci];
                    carve_we = 1'b1;
                    carve_next = carve_reg[ci] + step;
                    left_we = 1'b1;
                    left_next = left_reg[ci] - 1'b1;
                end else if (req_reg.page_valid && cap != '0) begin
                    grant = pg_gran;
                    carve_we = 1'b1;
                    carve_next = pg_gran + step;
                    left_we = 1'b1;
                    left_next = scsa_pkg::LEFT_W'(cap - 1'b1);
                    rsp_next.page_taken = 1'b1;
                end else begin
                    ok = 1'b0;
                end
                if (ok && cnt_reg[ci] != (scsa_pkg::CNT_W'(1) << GW)) begin
                    cnt_we = 1'b1;
                    cnt_next = cnt_reg[ci] + 1'b1;
                end
                rsp_next.class_in_use = cnt_next;
                rsp_next.status = ok ? scsa_pkg::ST_ALLOC : scsa_pkg::ST_FAILED;
                rsp_next.granted_offset = scsa_pkg::OFF_W'({grant, 3'd0});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= req;
            cls_reg <= cls_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NC; i++) begin
                head_reg[i]  <= '0;
                carve_reg[i] <= '0;
                left_reg[i]  <= '0;
                cnt_reg[i]   <= '0;
            end
        end else if (cmd.exec) begin
            if (head_we)  head_reg[ci]  <= head_next;
            if (carve_we) carve_reg[ci] <= carve_next;
            if (left_we)  left_reg[ci]  <= left_next;
            if (cnt_we)   cnt_reg[ci]   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;
endmodule

// ===== rtl/core/size_class_slab_allocator.sv =====
// top level of the size-class slab allocator
// a request is taken in the idle state and its class link is read at that edge;
// the class tables and the result register are updated in the exec state, and the
// result is presented in the out state and held until m_tready takes it; the link ram
// read, the table update and the result register come first, and no new request is taken until the result is taken
// reset: aresetn synchronous active low empties every class, no clearing pass
module size_class_slab_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode, size_bytes, object_present, object_offset, page_valid, page_offset
    input  logic [scsa_pkg::IN_BYTES_W-1:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status, granted_offset, size_class, page_taken, class_in_use
    output logic [scsa_pkg::OUT_BYTES_W-1:0] m_tdata
);
    scsa_pkg::cmd_t cmd;
    scsa_pkg::req_t req;
    scsa_pkg::rsp_t rsp;

    // unpack fields, first field in the lowest bits
    assign req.opcode         = s_tdata[0];
    assign req.size_bytes     = s_tdata[32:1];
    assign req.object_present = s_tdata[33];
    assign req.object_offset  = s_tdata[52:34];
    assign req.page_valid     = s_tdata[53];
    assign req.page_offset    = s_tdata[72:54];

    scsa_ctrl u_ctrl (
        .aclk (aclk), .aresetn (aresetn), .s_tvalid (s_tvalid), .s_tready (s_tready),
        .m_tvalid (m_tvalid), .m_tready (m_tready), .cmd (cmd)
    );

    scsa_dp u_dp (
        .aclk (aclk), .aresetn (aresetn), .cmd (cmd), .req (req), .rsp (rsp)
    );

    // pack result, status in the lowest bits, zero fill to whole bytes
    assign m_tdata = scsa_pkg::OUT_BYTES_W'({rsp.class_in_use, rsp.page_taken,
                     rsp.size_class, rsp.granted_offset, rsp.status});
endmodule

// ===== rtl/core/scsa_checker.sv =====
// port-level checks of the slab allocator, bound to the top level
`include "size_class_slab_allocator_defines.svh"
module scsa_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [scsa_pkg::OUT_BYTES_W-1:0] m_tdata
);
    // one request in flight: input closed while a result waits
    `SCSA_ASSERT_IMP(a_one_flight, aclk, aresetn, m_tvalid, !s_tready)
    // an accepted request passes through the exec state and then presents its result
    `SCSA_ASSERT_NXT(a_result_follows, aclk, aresetn, s_tvalid && s_tready, ##1 m_tvalid)
    // status code never above ignored
    `SCSA_ASSERT_IMP(a_status_range, aclk, aresetn, m_tvalid, m_tdata[2:0] <= 3'd4)
    // stalled result holds
    `SCSA_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
endmodule

bind size_class_slab_allocator scsa_checker u_scsa_checker (
    .aclk (aclk), .aresetn (aresetn), .s_tvalid (s_tvalid), .s_tready (s_tready),
    .m_tvalid (m_tvalid), .m_tready (m_tready), .m_tdata (m_tdata)
);

// ===== dv/tb_top.sv =====
// self-checking testbench for the size-class slab allocator
module tb_top;
    import scsa_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 60;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_BYTES_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_BYTES_W-1:0] m_tdata;

    size_class_slab_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // request as it travels in tdata, first field lowest
    typedef struct {
        logic              opcode;
        logic [31:0]       size_bytes;
        logic              object_present;
        logic [OFF_W-1:0]  object_offset;
        logic              page_valid;
        logic [OFF_W-1:0]  page_offset;
    } slab_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OFF_W-1:0]  granted_offset;
        logic [CLS_W-1:0]  size_class;
        logic              page_taken;
        logic [CNT_W-1:0]  class_in_use;
    } slab_rsp_t;

    slab_req_t pending_reqs[$];
    slab_rsp_t awaited_rsps[$];

    // allocator shadow state
    logic [LINK_W-1:0] shadow_head[NUM_CLASSES];
    logic [GRAN_W-1:0] shadow_carve[NUM_CLASSES];
    int unsigned       shadow_left[NUM_CLASSES];
    int unsigned       shadow_count[NUM_CLASSES];
    logic [LINK_W-1:0] shadow_link[int unsigned];

    int errors = 0;
    int idle_cycles = 0;
    bit hold_rx = 1'b0;
    bit pause_tx = 1'b0;
    bit stim_done = 1'b0;

    function automatic int class_of(logic [31:0] sz);
        for (int c = 0; c < NUM_CLASSES; c++)
            if (64'(sz) <= (64'd8 << c)) return c;
        return NUM_CLASSES;
    endfunction

    function automatic logic [IN_BYTES_W-1:0] pack_req(slab_req_t r);
        return IN_BYTES_W'({r.page_offset, r.page_valid, r.object_offset,
                            r.object_present, r.size_bytes, r.opcode});
    endfunction

    // advance shadow state and return the result the block should give
    function automatic slab_rsp_t serve_request(slab_req_t r);
        slab_rsp_t o;
        int c;
        logic [GRAN_W-1:0] obj, grant;
        int unsigned cap;
        o = '{ST_IGNORED, '0, '0, 1'b0, '0};
        obj = GRAN_W'(r.object_offset >> 3);
        if (r.opcode == OP_FREE) begin
            if (!r.object_present) return o;
            c = class_of(r.size_bytes);
            if (c >= NUM_CLASSES) begin
                o.status = ST_LARGE;
                return o;
            end
            shadow_link[obj] = shadow_head[c];
            shadow_head[c] = {1'b1, obj};
            if (shadow_count[c] > 0) shadow_count[c]--;
            o.status = ST_FREED;
            o.size_class = CLS_W'(c);
            o.class_in_use = CNT_W'(shadow_count[c]);
            return o;
        end
        if (r.size_bytes == 0) return o;
        c = class_of(r.size_bytes);
        if (c >= NUM_CLASSES) begin
            o.status = ST_LARGE;
            return o;
        end
        cap = PAGE_BYTES >> (c + 3);
        o.size_class = CLS_W'(c);
        if (shadow_head[c][LINK_W-1]) begin
            grant = shadow_head[c][GRAN_W-1:0];
            shadow_head[c] = shadow_link[grant];
        end else if (shadow_left[c] > 0) begin
            grant = shadow_carve[c];
            shadow_carve[c] = shadow_carve[c] + GRAN_W'(1 << c);
            shadow_left[c]--;
        end else if (r.page_valid && cap > 0) begin
            grant = GRAN_W'((r.page_offset >> 12) << 9);
            shadow_carve[c] = grant + GRAN_W'(1 << c);
            shadow_left[c] = cap - 1;
            o.page_taken = 1'b1;
        end else begin
            o.status = ST_FAILED;
            o.class_in_use = CNT_W'(shadow_count[c]);
            return o;
        end
        if (shadow_count[c] < (1 << ARENA_GRANULES_LOG2)) shadow_count[c]++;
        o.status = ST_ALLOC;
        o.granted_offset = OFF_W'({grant, 3'b000});
        o.class_in_use = CNT_W'(shadow_count[c]);
        return o;
    endfunction

    function automatic slab_req_t alloc_req(logic [31:0] sz, bit pv, logic [OFF_W-1:0] pg);
        slab_req_t r;
        r = '{OP_ALLOC, sz, 1'($urandom), OFF_W'($urandom), pv, pg};
        return r;
    endfunction

    function automatic slab_req_t free_req(logic [31:0] sz, bit pres, logic [OFF_W-1:0] off);
        slab_req_t r;
        r = '{OP_FREE, sz, pres, off, 1'($urandom), OFF_W'($urandom)};
        return r;
    endfunction

    // size that lands in a class, anywhere in its range
    function automatic logic [31:0] size_in_class(int c);
        if (c == 0) return $urandom_range(1, 8);
        return $urandom_range((8 << (c - 1)) + 1, 8 << c);
    endfunction

    initial begin
        forever #2 aclk = ~aclk;
    end

    // driver, predicts each request as it is accepted, in request order
    int tx_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                awaited_rsps.push_back(serve_request(pending_reqs.pop_front()));
                tx_gap = $urandom_range(0, 8);
                if ($urandom_range(0, 3) == 0) tx_gap = 0;
            end
            if (pending_reqs.size() == 0 || (pause_tx && !(s_tvalid && !s_tready))) begin
                s_tvalid <= 1'b0;
            end else if (tx_gap > 0 && !(s_tvalid && !s_tready)) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata <= pack_req(pending_reqs[0]);
            end
        end
    end

    // monitor and receiver stalls
    int rx_gap = 0;
    always @(posedge aclk) begin
        slab_rsp_t got, exp_rsp;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                {got.class_in_use, got.page_taken, got.size_class,
                 got.granted_offset, got.status} = m_tdata[OUT_W-1:0];
                if (awaited_rsps.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %p", got);
                end else begin
                    exp_rsp = awaited_rsps.pop_front();
                    if (got != exp_rsp) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %p got %p", exp_rsp, got);
                    end
                end
                rx_gap = $urandom_range(0, 8);
                if ($urandom_range(0, 3) == 0) rx_gap = 0;
            end
            if (hold_rx) begin
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on acceptance
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || awaited_rsps.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int c;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            shadow_head[i] = '0;
            shadow_carve[i] = '0;
            shadow_left[i] = 0;
            shadow_count[i] = 0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: special cases and field extremes
        pending_reqs.push_back(alloc_req(32'd0, 1'b1, 19'd0));          // zero-size allocate
        pending_reqs.push_back(free_req(32'd5, 1'b0, 19'h7FFFF));       // null free
        pending_reqs.push_back(free_req(32'd0, 1'b1, 19'h7FFF8));       // zero-size free, class 0
        pending_reqs.push_back(alloc_req(32'd1, 1'b0, 19'h7FFFF));      // pops the pushed one
        pending_reqs.push_back(alloc_req(32'd8, 1'b0, 19'd0));          // no page: fails
        pending_reqs.push_back(alloc_req(32'd8, 1'b1, 19'd520192));     // takes top page
        pending_reqs.push_back(alloc_req(32'd9, 1'b1, 19'h7FFFF));
        pending_reqs.push_back(alloc_req(32'd16384, 1'b1, 19'd4096));   // above a page: fails
        pending_reqs.push_back(alloc_req(32'd16385, 1'b1, 19'd4096));   // delegated
        pending_reqs.push_back(alloc_req(32'hFFFFFFFF, 1'b1, 19'd0));
        pending_reqs.push_back(free_req(32'hFFFFFFFF, 1'b1, 19'd8));    // large free
        pending_reqs.push_back(free_req(32'd16384, 1'b1, 19'h7FFFF));   // big class still reused
        pending_reqs.push_back(alloc_req(32'd9000, 1'b0, 19'd0));
        pending_reqs.push_back(free_req(32'd4096, 1'b1, 19'd3));        // misaligned
        pending_reqs.push_back(free_req(32'd4096, 1'b1, 19'd3));        // double
        pending_reqs.push_back(alloc_req(32'd4096, 1'b1, 19'd8192));
        pending_reqs.push_back(alloc_req(32'd4096, 1'b0, 19'd0));
        pending_reqs.push_back(alloc_req(32'd2048, 1'b1, 19'd12288));   // two objects per page
        pending_reqs.push_back(alloc_req(32'd2048, 1'b0, 19'd0));
        pending_reqs.push_back(free_req(32'd3000, 1'b1, 19'd16384));    // count saturates at zero
        pending_reqs.push_back(free_req(32'd3000, 1'b1, 19'd16384));
        pending_reqs.push_back(free_req(32'd3000, 1'b1, 19'd24576));

        // receiver holds off while the sender keeps offering
        hold_rx = 1'b1;
        for (int i = 0; i < 12; i++)
            pending_reqs.push_back(alloc_req(size_in_class($urandom_range(0, 3)), 1'b1,
                                             OFF_W'($urandom_range(0, 127) << 12)));
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx = 1'b0;
        wait_drained();

        // sender pauses until all results are in
        for (int i = 0; i < 8; i++)
            pending_reqs.push_back(alloc_req(size_in_class($urandom_range(0, 5)), 1'b1,
                                             OFF_W'($urandom_range(0, 127) << 12)));
        while (pending_reqs.size() > 4) @(posedge aclk);
        pause_tx = 1'b1;
        while (awaited_rsps.size() != 0 || s_tvalid) @(posedge aclk);
        pause_tx = 1'b0;
        wait_drained();

        // random: mostly allocates and frees of random objects, some noise
        for (int i = 0; i < 2000; i++) begin
            c = $urandom_range(0, 11);
            if (c > 9) c = $urandom_range(0, 9);
            case ($urandom_range(0, 9))
                0: pending_reqs.push_back('{1'($urandom), $urandom, 1'($urandom),
                                            OFF_W'($urandom), 1'($urandom),
                                            OFF_W'($urandom)});
                1, 2, 3: pending_reqs.push_back(free_req(size_in_class(c), 1'b1,
                                                OFF_W'($urandom_range(0, 65535) << 3)));
                default: pending_reqs.push_back(alloc_req(size_in_class(c),
                                                $urandom_range(0, 4) != 0,
                                                OFF_W'($urandom_range(0, 127) << 12) |
                                                OFF_W'($urandom_range(0, 4095))));
            endcase
            if (pending_reqs.size() > 64) wait_drained();
        end
        wait_drained();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/scsa_pkg.sv
rtl/core/scsa_ram.sv
rtl/core/scsa_ctrl.sv
rtl/core/scsa_dp.sv
rtl/core/size_class_slab_allocator.sv
rtl/core/scsa_checker.sv
dv/tb_top.sv
